/* hdl/fos_pkg.sv */
// shared widths, codes and constants for the fuzzy obstacle steering block
`default_nettype none

package fos_pkg;

    localparam int CFG_BITS          = 10;
    localparam int CFG_INDEX_BITS    = 2;
    localparam int STRENGTH_BITS     = 9;
    localparam int STEER_BITS        = 16;
    localparam int MOVE_BITS         = 2;
    localparam int STEER_GAIN        = 50;
    localparam int MOVE_LIMIT        = 15;

    localparam logic [CFG_BITS-1:0] IR_NEAR_START_RST    = CFG_BITS'(100);
    localparam logic [CFG_BITS-1:0] IR_NEAR_END_RST      = CFG_BITS'(200);
    localparam logic [CFG_BITS-1:0] SONAR_NEAR_START_RST = CFG_BITS'(150);
    localparam logic [CFG_BITS-1:0] SONAR_NEAR_END_RST   = CFG_BITS'(300);

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_IR_NEAR_START    = CFG_INDEX_BITS'(0),
        CFG_IR_NEAR_END      = CFG_INDEX_BITS'(1),
        CFG_SONAR_NEAR_START = CFG_INDEX_BITS'(2),
        CFG_SONAR_NEAR_END   = CFG_INDEX_BITS'(3)
    } cfg_index_t;

    typedef enum logic [MOVE_BITS-1:0] {
        MOVE_FORWARD = MOVE_BITS'(0),
        MOVE_RIGHT   = MOVE_BITS'(1),
        MOVE_LEFT    = MOVE_BITS'(2)
    } move_kind_t;

endpackage

`default_nettype wire

/* hdl/fos_if.sv */
// valid/ready channel interfaces for sensor requests and steering results
`default_nettype none

interface fos_in_if #(
    parameter int DISTANCE_BITS = 10
);
    logic                     valid;
    logic                     ready;
    logic [DISTANCE_BITS-1:0] left_ir_distance;
    logic [DISTANCE_BITS-1:0] right_ir_distance;
    logic [DISTANCE_BITS-1:0] sonar_distance;

    modport source (
        output valid, left_ir_distance, right_ir_distance, sonar_distance,
        input  ready
    );
    modport sink (
        input  valid, left_ir_distance, right_ir_distance, sonar_distance,
        output ready
    );
endinterface

interface fos_out_if;
    import fos_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [STRENGTH_BITS-1:0]  left_strength;
    logic [STRENGTH_BITS-1:0]  right_strength;
    logic [STRENGTH_BITS-1:0]  forward_strength;
    logic signed [STEER_BITS-1:0] steer_value;
    logic [MOVE_BITS-1:0]      move_kind;

    modport source (
        output valid, left_strength, right_strength, forward_strength, steer_value,
               move_kind,
        input  ready
    );
    modport sink (
        input  valid, left_strength, right_strength, forward_strength, steer_value,
               move_kind,
        output ready
    );
endinterface

`default_nettype wire

/* hdl/fos_fuzzify.sv */
// near membership setup: turns a distance into a dividend and divisor
`default_nettype none

module fos_fuzzify #(
    parameter int DISTANCE_BITS = 10,
    parameter int FRACTION_BITS = 8
) (
    input  wire logic                                  clk,
    input  wire logic                                  en,
    input  wire logic [DISTANCE_BITS-1:0]              distance,
    input  wire logic [fos_pkg::CFG_BITS-1:0]          near_start,
    input  wire logic [fos_pkg::CFG_BITS-1:0]          near_end,
    output logic [fos_pkg::CFG_BITS+FRACTION_BITS+1:0] num,
    output logic [fos_pkg::CFG_BITS:0]                 den
);
    import fos_pkg::*;

    localparam int CW = (DISTANCE_BITS > CFG_BITS) ? DISTANCE_BITS : CFG_BITS;
    localparam int NW = CFG_BITS + FRACTION_BITS + 2;
    localparam int DW = CFG_BITS + 1;

    logic [CW-1:0]       d_x;
    logic [CW-1:0]       s_x;
    logic [CW-1:0]       e_x;
    logic [CW-1:0]       gap_w;
    logic [CFG_BITS-1:0] gap;
    logic [CFG_BITS-1:0] span;
    logic [NW-1:0]       num_next;
    logic [DW-1:0]       den_next;
    logic [NW-1:0]       num_reg;
    logic [DW-1:0]       den_reg;

    assign d_x   = CW'(distance);
    assign s_x   = CW'(near_start);
    assign e_x   = CW'(near_end);
    assign gap_w = e_x - d_x;
    assign gap   = gap_w[CFG_BITS-1:0];
    assign span  = near_end - near_start;

    // full and zero map onto a divide by two that yields one and zero
    always_comb
    begin
        if (d_x <= s_x)
        begin
            num_next = NW'(1) << (FRACTION_BITS + 1);
            den_next = DW'(2);
        end
        else if (d_x >= e_x)
        begin
            num_next = '0;
            den_next = DW'(2);
        end
        else
        begin
            num_next = (NW'(gap) << (FRACTION_BITS + 1)) + NW'(span);
            den_next = {span, 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg <= num_next;
            den_reg <= den_next;
        end
    end

    assign num = num_reg;
    assign den = den_reg;

endmodule

`default_nettype wire

/* hdl/fos_div.sv */
// pipelined restoring divider, one quotient bit per stage
`default_nettype none

module fos_div #(
    parameter int FRACTION_BITS = 8
) (
    input  wire logic                                  clk,
    input  wire logic [FRACTION_BITS:0]                en,
    input  wire logic [fos_pkg::CFG_BITS+FRACTION_BITS+1:0] num,
    input  wire logic [fos_pkg::CFG_BITS:0]            den,
    output logic [FRACTION_BITS:0]                     quo
);
    import fos_pkg::*;

    localparam int QW = FRACTION_BITS + 1;
    localparam int NW = CFG_BITS + FRACTION_BITS + 2;
    localparam int DW = CFG_BITS + 1;

    logic [NW-1:0] rem_reg [QW-1];
    logic [DW-1:0] den_reg [QW-1];
    logic [QW-1:0] quo_reg [QW];

    for (genvar k = 0; k < QW; k++)
    begin : g_stage
        localparam int SH = FRACTION_BITS - k;

        logic [NW-1:0] rem_in;
        logic [DW-1:0] den_in;
        logic [QW-1:0] quo_in;
        logic [NW-1:0] dsh;
        logic          fits;
        logic [QW-1:0] quo_next;

        if (k == 0)
        begin : g_first
            assign rem_in = num;
            assign den_in = den;
            assign quo_in = '0;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign den_in = den_reg[k-1];
            assign quo_in = quo_reg[k-1];
        end

        assign dsh  = NW'(den_in) << SH;
        assign fits = (rem_in >= dsh);

        always_comb
        begin
            if (fits)
            begin
                quo_next = quo_in | (QW'(1) << SH);
            end
            else
            begin
                quo_next = quo_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[k])
            begin
                quo_reg[k] <= quo_next;
            end
        end

        if (k < QW - 1)
        begin : g_carry
            logic [NW-1:0] rem_next;

            assign rem_next = fits ? (rem_in - dsh) : rem_in;

            always_ff @(posedge clk)
            begin
                if (en[k])
                begin
                    rem_reg[k] <= rem_next;
                    den_reg[k] <= den_in;
                end
            end
        end
    end

    assign quo = quo_reg[QW-1];

endmodule

`default_nettype wire

/* hdl/fos_rules.sv */
// min-max rule evaluation for left, right and forward strengths
`default_nettype none

module fos_rules #(
    parameter int FRACTION_BITS = 8
) (
    input  wire logic                   clk,
    input  wire logic                   en,
    input  wire logic [FRACTION_BITS:0] left_near,
    input  wire logic [FRACTION_BITS:0] right_near,
    input  wire logic [FRACTION_BITS:0] sonar_near,
    output logic [FRACTION_BITS:0]      left,
    output logic [FRACTION_BITS:0]      right,
    output logic [FRACTION_BITS:0]      fwd
);
    import fos_pkg::*;

    localparam int QW = FRACTION_BITS + 1;
    localparam logic [QW-1:0] ONE = QW'(1) << FRACTION_BITS;

    function automatic logic [QW-1:0] min3(input logic [QW-1:0] a, input logic [QW-1:0] b,
                                           input logic [QW-1:0] c);
        logic [QW-1:0] m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    function automatic logic [QW-1:0] max3(input logic [QW-1:0] a, input logic [QW-1:0] b,
                                           input logic [QW-1:0] c);
        logic [QW-1:0] m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    logic [QW-1:0] ln, rn, cn, lf, rf, cf;
    logic [QW-1:0] left_next, right_next, fwd_next;
    logic [QW-1:0] left_reg, right_reg, fwd_reg;

    assign ln = left_near;
    assign rn = right_near;
    assign cn = sonar_near;
    assign lf = ONE - ln;
    assign rf = ONE - rn;
    assign cf = ONE - cn;

    assign left_next  = max3(min3(ln, cf, rn), min3(lf, cn, rn), min3(lf, cf, rn));
    assign right_next = max3(min3(ln, cn, rf), min3(ln, cf, rf), min3(lf, cn, rf));
    assign fwd_next   = min3(ln, rn, cn);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            left_reg  <= left_next;
            right_reg <= right_next;
            fwd_reg   <= fwd_next;
        end
    end

    assign left  = left_reg;
    assign right = right_reg;
    assign fwd   = fwd_reg;

endmodule

`default_nettype wire

/* hdl/fos_steer.sv */
// steering value, move decision and the output register
`default_nettype none

module fos_steer #(
    parameter int FRACTION_BITS = 8
) (
    input  wire logic                              clk,
    input  wire logic                              en,
    input  wire logic [FRACTION_BITS:0]            left,
    input  wire logic [FRACTION_BITS:0]            right,
    input  wire logic [FRACTION_BITS:0]            fwd,
    output logic [fos_pkg::STRENGTH_BITS-1:0]      left_strength,
    output logic [fos_pkg::STRENGTH_BITS-1:0]      right_strength,
    output logic [fos_pkg::STRENGTH_BITS-1:0]      forward_strength,
    output logic signed [fos_pkg::STEER_BITS-1:0]  steer_value,
    output logic [fos_pkg::MOVE_BITS-1:0]          move_kind
);
    import fos_pkg::*;

    localparam int QW = FRACTION_BITS + 1;
    localparam int DFW = FRACTION_BITS + 2;
    localparam int SW = FRACTION_BITS + 8;
    localparam int XW = (QW > STRENGTH_BITS) ? QW : STRENGTH_BITS;
    localparam int EW = (SW > STEER_BITS) ? SW : STEER_BITS;
    localparam logic signed [SW-1:0] LIMIT = SW'(MOVE_LIMIT) <<< FRACTION_BITS;

    logic signed [DFW-1:0] tr;
    logic signed [DFW-1:0] tl;
    logic signed [DFW-1:0] diff;
    logic signed [SW-1:0]  steer_full;
    logic signed [EW-1:0]  steer_ext;
    logic [XW-1:0]         left_x, right_x, fwd_x;
    move_kind_t            kind_next;

    logic [STRENGTH_BITS-1:0]     left_reg, right_reg, fwd_reg;
    logic signed [STEER_BITS-1:0] steer_reg;
    move_kind_t                   kind_reg;

    // each term drops out when forward already dominates that side
    assign tr   = (fwd > right) ? '0 : signed'(DFW'(right)) - signed'(DFW'(fwd));
    assign tl   = (fwd > left)  ? '0 : signed'(DFW'(left))  - signed'(DFW'(fwd));
    assign diff = tr - tl;

    assign steer_full = SW'(diff) * signed'(SW'(STEER_GAIN));
    assign steer_ext  = EW'(steer_full);

    always_comb
    begin
        if (steer_full > LIMIT)
        begin
            kind_next = MOVE_RIGHT;
        end
        else if (steer_full < -LIMIT)
        begin
            kind_next = MOVE_LEFT;
        end
        else
        begin
            kind_next = MOVE_FORWARD;
        end
    end

    assign left_x  = XW'(left);
    assign right_x = XW'(right);
    assign fwd_x   = XW'(fwd);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            left_reg  <= left_x[STRENGTH_BITS-1:0];
            right_reg <= right_x[STRENGTH_BITS-1:0];
            fwd_reg   <= fwd_x[STRENGTH_BITS-1:0];
            steer_reg <= steer_ext[STEER_BITS-1:0];
            kind_reg  <= kind_next;
        end
    end

    assign left_strength    = left_reg;
    assign right_strength   = right_reg;
    assign forward_strength = fwd_reg;
    assign steer_value      = steer_reg;
    assign move_kind        = kind_reg;

endmodule

`default_nettype wire

/* hdl/fuzzy_obstacle_steering.sv */
// fuzzy obstacle steering top level: config registers, stage control, datapath
// path from request to result: fuzzify register, divider stages, rules register, output register
// throughput: one request per cycle, set by the one-bit-per-stage divider pipeline
// a stalled result holds the last stage; earlier empty stages keep taking requests
// reset clears all stage valid bits and loads the default thresholds
`default_nettype none

module fuzzy_obstacle_steering #(
    parameter int DISTANCE_BITS = 10,
    parameter int FRACTION_BITS = 8
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_write,
    input  wire logic [fos_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [fos_pkg::CFG_BITS-1:0]        cfg_data,
    fos_in_if.sink                                   sensors,
    fos_out_if.source                                steering
);
    import fos_pkg::*;

    localparam int QW = FRACTION_BITS + 1;
    localparam int NW = CFG_BITS + FRACTION_BITS + 2;
    localparam int DW = CFG_BITS + 1;
    localparam int STAGES = FRACTION_BITS + 4;
    localparam int DIV_FIRST = 1;
    localparam int RULES_STAGE = FRACTION_BITS + 2;
    localparam int OUT_STAGE = FRACTION_BITS + 3;

    logic [CFG_BITS-1:0] ir_start_reg, ir_end_reg, sonar_start_reg, sonar_end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ir_start_reg    <= IR_NEAR_START_RST;
            ir_end_reg      <= IR_NEAR_END_RST;
            sonar_start_reg <= SONAR_NEAR_START_RST;
            sonar_end_reg   <= SONAR_NEAR_END_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_IR_NEAR_START:    ir_start_reg    <= cfg_data;
                CFG_IR_NEAR_END:      ir_end_reg      <= cfg_data;
                CFG_SONAR_NEAR_START: sonar_start_reg <= cfg_data;
                CFG_SONAR_NEAR_END:   sonar_end_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // stage control: a stage loads when it is empty or its contents move on
    logic [STAGES-1:0] v_reg;
    logic [STAGES-1:0] ld;

    always_comb
    begin
        ld[STAGES-1] = !v_reg[STAGES-1] || steering.ready;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            ld[k] = !v_reg[k] || ld[k+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (ld[0])
            begin
                v_reg[0] <= sensors.valid;
            end
            for (int k = 1; k < STAGES; k++)
            begin
                if (ld[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    assign sensors.ready  = ld[0];
    assign steering.valid = v_reg[OUT_STAGE];

    logic [NW-1:0] l_num, r_num, c_num;
    logic [DW-1:0] l_den, r_den, c_den;
    logic [QW-1:0] l_near, r_near, c_near;
    logic [QW-1:0] left_s, right_s, fwd_s;
    logic [QW-1:0] div_en;

    assign div_en = ld[DIV_FIRST +: QW];

    fos_fuzzify #(.DISTANCE_BITS(DISTANCE_BITS), .FRACTION_BITS(FRACTION_BITS)) u_fuzz_l (
        .clk        (clk),
        .en         (ld[0]),
        .distance   (sensors.left_ir_distance),
        .near_start (ir_start_reg),
        .near_end   (ir_end_reg),
        .num        (l_num),
        .den        (l_den)
    );

    fos_fuzzify #(.DISTANCE_BITS(DISTANCE_BITS), .FRACTION_BITS(FRACTION_BITS)) u_fuzz_r (
        .clk        (clk),
        .en         (ld[0]),
        .distance   (sensors.right_ir_distance),
        .near_start (ir_start_reg),
        .near_end   (ir_end_reg),
        .num        (r_num),
        .den        (r_den)
    );

    fos_fuzzify #(.DISTANCE_BITS(DISTANCE_BITS), .FRACTION_BITS(FRACTION_BITS)) u_fuzz_c (
        .clk        (clk),
        .en         (ld[0]),
        .distance   (sensors.sonar_distance),
        .near_start (sonar_start_reg),
        .near_end   (sonar_end_reg),
        .num        (c_num),
        .den        (c_den)
    );

    fos_div #(.FRACTION_BITS(FRACTION_BITS)) u_div_l (
        .clk (clk),
        .en  (div_en),
        .num (l_num),
        .den (l_den),
        .quo (l_near)
    );

    fos_div #(.FRACTION_BITS(FRACTION_BITS)) u_div_r (
        .clk (clk),
        .en  (div_en),
        .num (r_num),
        .den (r_den),
        .quo (r_near)
    );

    fos_div #(.FRACTION_BITS(FRACTION_BITS)) u_div_c (
        .clk (clk),
        .en  (div_en),
        .num (c_num),
        .den (c_den),
        .quo (c_near)
    );

    fos_rules #(.FRACTION_BITS(FRACTION_BITS)) u_rules (
        .clk        (clk),
        .en         (ld[RULES_STAGE]),
        .left_near  (l_near),
        .right_near (r_near),
        .sonar_near (c_near),
        .left       (left_s),
        .right      (right_s),
        .fwd        (fwd_s)
    );

    fos_steer #(.FRACTION_BITS(FRACTION_BITS)) u_steer (
        .clk              (clk),
        .en               (ld[OUT_STAGE]),
        .left             (left_s),
        .right            (right_s),
        .fwd              (fwd_s),
        .left_strength    (steering.left_strength),
        .right_strength   (steering.right_strength),
        .forward_strength (steering.forward_strength),
        .steer_value      (steering.steer_value),
        .move_kind        (steering.move_kind)
    );

endmodule

`default_nettype wire
